[sv/isfr_pkg.sv]
package isfr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_PIXELS_DEF  = 4096;
    localparam int PIX_W           = 8;
    localparam int DIM_OUT_W       = 13;
    localparam int QUOT_W          = 8;
    localparam int DIFF_W          = SAMPLE_BITS + 1;
    localparam int NUM_W           = DIFF_W + QUOT_W;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd254;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_FLIP   = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [SAMPLE_BITS-1:0] sample;
    } cmd_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic                 last;
        logic [1:0]           status;
        logic [DIM_OUT_W-1:0] cur_width_out;
        logic [DIM_OUT_W-1:0] cur_height_out;
    } res_word_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DIFF_W-1:0] den;
    } div_req_t;

endpackage

[sv/isfr_ram.sv]
module isfr_ram
    import isfr_pkg::*;
#(
    parameter int DEPTH = MAX_PIXELS_DEF,
    parameter int AW    = $clog2(MAX_PIXELS_DEF)
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic [AW-1:0]          raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/isfr_div.sv]
module isfr_div
    import isfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam int CW = $clog2(QUOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] q_reg, q_next;

    // one compare and subtract per cycle, quotient bit msb first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            dsh_next  = NUM_W'(req.den) << (QUOT_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[sv/image_store_flip_rotate_normalize_unit.sv]
// channel   direction  handshake            word
// cmd       in         cmd_valid/cmd_stall  cmd_word (kind, sample)
// res       out        res_valid/res_stall  res_word (pixel, last, status, width, height)
// cfg       in         cfg_we               cfg_wdata (initial width)
//
// append, or any command on an empty image: straight to the output handoff
// read: S_RD, plus S_DIV when the 8-step compare/subtract divider runs, then handoff
// flip and rotate: one pass into scratch, one pass back with range rescan
// reset is asynchronous and clears sequencer state, geometry, range and cursor;
// walker registers, result payload and memories are not cleared
// cmd_stall is high while a word is in progress; a result waits in a register
// until res_stall drops
module image_store_flip_rotate_normalize_unit
    import isfr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_word_t            cmd_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_word_t            res_word,
    input  logic                 cfg_we,
    input  logic [DIM_OUT_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(MAX_PIXELS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int DIM_W = (CNT_W > DIM_OUT_W) ? CNT_W : DIM_OUT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P1   = 3'd1;   // store -> scratch, permuted
    localparam logic [2:0] S_P2   = 3'd2;   // scratch -> store, range rescan
    localparam logic [2:0] S_RD   = 3'd3;   // pixel read data back
    localparam logic [2:0] S_DIV  = 3'd4;   // waiting on divider
    localparam logic [2:0] S_DONE = 3'd5;   // result handoff

    localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [2:0]                    state_reg, state_next;
    logic [DIM_W-1:0]              cur_w_reg, cur_w_next;
    logic [DIM_W-1:0]              cur_h_reg, cur_h_next;
    logic [DIM_W-1:0]              fill_reg, fill_next;
    logic [CNT_W-1:0]              area_reg, area_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [AW-1:0]                 cursor_reg, cursor_next;
    logic                          rot_reg, rot_next;
    logic [CNT_W-1:0]              src_reg, src_next;
    logic [CNT_W-1:0]              x_reg, x_next;
    logic [CNT_W-1:0]              rs_reg, rs_next;
    logic [CNT_W-1:0]              dst_reg, dst_next;
    logic [CNT_W-1:0]              col_step_reg, col_step_next;
    logic [CNT_W-1:0]              row_step_reg, row_step_next;
    logic                          p_valid_reg, p_valid_next;
    logic [CNT_W-1:0]              p_addr_reg, p_addr_next;
    logic [PIX_W-1:0]              pix_reg, pix_next;
    logic                          last_reg, last_next;
    logic [1:0]                    status_reg, status_next;
    logic                          res_valid_reg, res_valid_next;
    res_word_t                     res_word_reg, res_word_next;

    // memory ports
    logic                   st_we;
    logic [AW-1:0]          st_waddr, st_raddr;
    logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;
    logic                   sc_we;
    logic [AW-1:0]          sc_waddr, sc_raddr;
    logic [SAMPLE_BITS-1:0] sc_rdata;

    div_req_t          div_req;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    // helpers
    logic [CNT_W-1:0]              w_c, h_c;
    logic [DIM_W:0]                pos;
    logic [DIM_W-1:0]              fill_inc;
    logic [CNT_W-1:0]              idx, idx_inc;
    logic signed [SAMPLE_BITS-1:0] v_app, v_cp, v_rd;
    logic signed [DIFF_W-1:0]      diff, off;
    logic [NUM_W-1:0]              off_ext;

    assign w_c      = cur_w_reg[CNT_W-1:0];
    assign h_c      = cur_h_reg[CNT_W-1:0];
    assign pos      = (DIM_W+1)'(area_reg) + (DIM_W+1)'(fill_reg);
    assign fill_inc = fill_reg + DIM_W'(1);
    assign idx      = ({1'b0, cursor_reg} >= (AW+1)'(area_reg)) ? '0 : CNT_W'(cursor_reg);
    assign idx_inc  = idx + CNT_W'(1);
    assign v_app    = cmd_word.sample;
    assign v_cp     = sc_rdata;
    assign v_rd     = st_rdata;
    assign diff     = DIFF_W'(max_reg) - DIFF_W'(min_reg);
    assign off      = DIFF_W'(v_rd) - DIFF_W'(min_reg);
    assign off_ext  = NUM_W'(off[DIFF_W-1:0]);

    always_comb
    begin
        state_next     = state_reg;
        cur_w_next     = cur_w_reg;
        cur_h_next     = cur_h_reg;
        fill_next      = fill_reg;
        area_next      = area_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        cursor_next    = cursor_reg;
        rot_next       = rot_reg;
        src_next       = src_reg;
        x_next         = x_reg;
        rs_next        = rs_reg;
        dst_next       = dst_reg;
        col_step_next  = col_step_reg;
        row_step_next  = row_step_reg;
        p_valid_next   = 1'b0;
        p_addr_next    = p_addr_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg & res_stall;
        res_word_next  = res_word_reg;

        st_we    = 1'b0;
        st_waddr = p_addr_reg[AW-1:0];
        st_wdata = sc_rdata;
        st_raddr = idx[AW-1:0];
        sc_we    = 1'b0;
        sc_waddr = p_addr_reg[AW-1:0];
        sc_raddr = src_reg[AW-1:0];

        div_req.start = 1'b0;
        div_req.num   = (off_ext << QUOT_W) - (off_ext << 1);   // off * 254
        div_req.den   = diff;

        // width follows the register only while nothing is stored
        if (cfg_we && cur_h_reg == '0 && fill_reg == '0)
        begin
            cur_w_next = DIM_W'(cfg_wdata);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pix_next    = '0;
                    last_next   = 1'b0;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                    unique case (cmd_word.kind)
                        KIND_APPEND:
                        begin
                            if (cur_w_reg == '0 || pos >= (DIM_W+1)'(MAX_PIXELS))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = pos[AW-1:0];
                                st_wdata = v_app;
                                if (v_app < min_reg) min_next = v_app;
                                if (v_app > max_reg) max_next = v_app;
                                if (fill_inc >= cur_w_reg)
                                begin
                                    fill_next  = '0;
                                    cur_h_next = cur_h_reg + DIM_W'(1);
                                    area_next  = area_reg + w_c;
                                end
                                else
                                begin
                                    fill_next = fill_inc;
                                end
                            end
                        end
                        KIND_FLIP, KIND_ROTATE:
                        begin
                            if (area_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rot_next   = (cmd_word.kind == KIND_ROTATE);
                                src_next   = '0;
                                x_next     = '0;
                                state_next = S_P1;
                                if (cmd_word.kind == KIND_ROTATE)
                                begin
                                    // first source pixel lands in the last row, column 0
                                    rs_next       = area_reg - h_c;
                                    dst_next      = area_reg - h_c;
                                    col_step_next = h_c;
                                    row_step_next = CNT_W'(1);
                                end
                                else
                                begin
                                    rs_next       = w_c - CNT_W'(1);
                                    dst_next      = w_c - CNT_W'(1);
                                    col_step_next = CNT_W'(1);
                                    row_step_next = w_c;
                                end
                            end
                        end
                        KIND_READ:
                        begin
                            if (area_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                st_raddr = idx[AW-1:0];
                                if (idx_inc >= area_reg)
                                begin
                                    last_next   = 1'b1;
                                    cursor_next = '0;
                                end
                                else
                                begin
                                    cursor_next = idx_inc[AW-1:0];
                                end
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            S_P1:
            begin
                // write the word read last cycle into its permuted slot
                if (p_valid_reg)
                begin
                    sc_we    = 1'b1;
                    sc_waddr = p_addr_reg[AW-1:0];
                end
                if (src_reg < area_reg)
                begin
                    st_raddr     = src_reg[AW-1:0];
                    p_valid_next = 1'b1;
                    p_addr_next  = dst_reg;
                    src_next     = src_reg + CNT_W'(1);
                    if (x_reg + CNT_W'(1) == w_c)
                    begin
                        x_next   = '0;
                        rs_next  = rs_reg + row_step_reg;
                        dst_next = rs_reg + row_step_reg;
                    end
                    else
                    begin
                        x_next   = x_reg + CNT_W'(1);
                        dst_next = dst_reg - col_step_reg;
                    end
                end
                else if (!p_valid_reg)
                begin
                    src_next   = '0;
                    min_next   = MIN_INIT;
                    max_next   = MAX_INIT;
                    state_next = S_P2;
                end
            end

            S_P2:
            begin
                if (p_valid_reg)
                begin
                    st_we    = 1'b1;
                    st_waddr = p_addr_reg[AW-1:0];
                    st_wdata = v_cp;
                    if (v_cp < min_reg) min_next = v_cp;
                    if (v_cp > max_reg) max_next = v_cp;
                end
                if (src_reg < area_reg)
                begin
                    sc_raddr     = src_reg[AW-1:0];
                    p_valid_next = 1'b1;
                    p_addr_next  = src_reg;
                    src_next     = src_reg + CNT_W'(1);
                end
                else if (!p_valid_reg)
                begin
                    fill_next = '0;
                    if (rot_reg)
                    begin
                        cur_w_next = cur_h_reg;
                        cur_h_next = cur_w_reg;
                    end
                    state_next = S_DONE;
                end
            end

            S_RD:
            begin
                if (diff[DIFF_W-1] || diff == '0 || off[DIFF_W-1] || off == '0)
                begin
                    pix_next   = '0;
                    state_next = S_DONE;
                end
                else if (off >= diff)
                begin
                    pix_next   = PIX_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    pix_next   = div_quot;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next               = 1'b1;
                    res_word_next.pixel          = pix_reg;
                    res_word_next.last           = last_reg;
                    res_word_next.status         = status_reg;
                    res_word_next.cur_width_out  = cur_w_reg[DIM_OUT_W-1:0];
                    res_word_next.cur_height_out = cur_h_reg[DIM_OUT_W-1:0];
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_w_reg     <= '0;
            cur_h_reg     <= '0;
            fill_reg      <= '0;
            area_reg      <= '0;
            min_reg       <= MIN_INIT;
            max_reg       <= MAX_INIT;
            cursor_reg    <= '0;
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_w_reg     <= cur_w_next;
            cur_h_reg     <= cur_h_next;
            fill_reg      <= fill_next;
            area_reg      <= area_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            cursor_reg    <= cursor_next;
            p_valid_reg   <= p_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // walker and result payload
    always_ff @(posedge clk)
    begin
        rot_reg      <= rot_next;
        src_reg      <= src_next;
        x_reg        <= x_next;
        rs_reg       <= rs_next;
        dst_reg      <= dst_next;
        col_step_reg <= col_step_next;
        row_step_reg <= row_step_next;
        p_addr_reg   <= p_addr_next;
        pix_reg      <= pix_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        res_word_reg <= res_word_next;
    end

    isfr_ram #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    isfr_ram #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_scratch_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (st_rdata),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    isfr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
